FILE: rtl/periodic_task_ready_scheduler_macros.svh
// Assertion macros used by the scheduler top level.
`ifndef PERIODIC_TASK_READY_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_READY_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PTRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define PTRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ptrs_pkg.sv
// Shared types and constants of the periodic task ready scheduler.
package ptrs_pkg;

	// Default sizes
	localparam int PTRS_MAX_TASKS   = 16;
	localparam int PTRS_COUNT_WIDTH = 16;

	// Fixed field widths
	localparam int OP_W     = 3;
	localparam int TIDX_W   = 4;
	localparam int PV_W     = 16;
	localparam int MASK_W   = 16;
	localparam int ACTIVE_W = 5;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_TICK    = 3'd0,
		OP_EXEC    = 3'd1,
		OP_SUSPEND = 3'd2,
		OP_RESUME  = 3'd3,
		OP_QUERY   = 3'd4,
		OP_LOAD    = 3'd5
	} op_t;

	// Task states
	typedef enum logic [1:0] {
		ST_STOP = 2'd0,
		ST_RUN  = 2'd1,
		ST_SUSP = 2'd2
	} task_st_t;

	// Sequencer states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_WALK = 1'b1
	} seq_st_t;

	// Control handed to the head update logic
	typedef struct packed {
		op_t  op;
		logic live; // entry at the head is below the active count
		logic hit;  // entry at the head is the addressed one
	} head_ctl_t;

endpackage

FILE: rtl/ptrs_cell.sv
// One task entry of the ring: period, countdown and state, loaded from its neighbor.
module ptrs_cell #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic [COUNT_WIDTH-1:0] d_period,
	input  logic [COUNT_WIDTH-1:0] d_count,
	input  ptrs_pkg::task_st_t     d_state,
	output logic [COUNT_WIDTH-1:0] q_period,
	output logic [COUNT_WIDTH-1:0] q_count,
	output ptrs_pkg::task_st_t     q_state
);
	import ptrs_pkg::*;

	logic [COUNT_WIDTH-1:0] period_q;
	logic [COUNT_WIDTH-1:0] count_q;
	task_st_t               state_q;

	// Entry storage, takes the neighbor's entry on every ring step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			count_q  <= '0;
			state_q  <= ST_STOP;
		end else if (shift) begin
			period_q <= d_period;
			count_q  <= d_count;
			state_q  <= d_state;
		end
	end

	assign q_period = period_q;
	assign q_count  = count_q;
	assign q_state  = state_q;

endmodule

FILE: rtl/ptrs_head.sv
// Update of the entry leaving the ring head for the current operation.
module ptrs_head #(
	parameter int COUNT_WIDTH = 16
) (
	input  ptrs_pkg::head_ctl_t           ctl,
	input  logic [ptrs_pkg::PV_W-1:0]     period_value,
	input  logic [COUNT_WIDTH-1:0]        i_period,
	input  logic [COUNT_WIDTH-1:0]        i_count,
	input  ptrs_pkg::task_st_t            i_state,
	output logic [COUNT_WIDTH-1:0]        o_period,
	output logic [COUNT_WIDTH-1:0]        o_count,
	output ptrs_pkg::task_st_t            o_state,
	output logic                          was_run
);
	import ptrs_pkg::*;

	logic [COUNT_WIDTH-1:0] dec;

	// Countdown after the tick decrement (holds at zero)
	assign dec = (i_count != '0) ? (i_count - COUNT_WIDTH'(1)) : i_count;

	always_comb begin
		o_period = i_period;
		o_count  = i_count;
		o_state  = i_state;
		was_run  = 1'b0;
		case (ctl.op)
			OP_TICK: begin
				if (ctl.live && (i_state != ST_SUSP)) begin
					o_count = dec;
					if (dec == '0) begin
						o_state = ST_RUN;
						o_count = i_period;
					end
				end
			end
			OP_EXEC: begin
				if (ctl.live && (i_state == ST_RUN)) begin
					was_run = 1'b1;
					o_state = ST_STOP;
				end
			end
			OP_SUSPEND: begin
				if (ctl.hit) begin
					o_state = ST_SUSP;
				end
			end
			OP_RESUME: begin
				if (ctl.hit) begin
					o_count = i_period;
					o_state = ST_RUN;
				end
			end
			OP_LOAD: begin
				if (ctl.hit) begin
					o_period = COUNT_WIDTH'(period_value);
					o_count  = COUNT_WIDTH'(period_value);
				end
			end
			default: begin
				// query and unknown codes leave the entry as it is
			end
		endcase
	end

endmodule

FILE: rtl/periodic_task_ready_scheduler.sv
// Top level: task ring of cells, head update and walk sequencer.
//
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+--------------------------------------
// command  | in        | start & !busy          | op, task_index, period_value
// result   | out       | done (one cycle)       | ready_mask, task_state, index_valid
// config   | in        | cfg_valid & cfg_ready  | cfg_data (active_tasks)
//
// Every operation walks the whole ring: the entries rotate one cell per cycle through
// the head update, and the result strobe is registered from the last walk step, so it
// follows in the next cycle; busy stays high and no new command is taken until then.
// Reset clears every entry to stop with zero period and countdown, active_tasks to 16.
// The result cannot be stalled; cfg_ready is low while a walk is in progress.
`include "periodic_task_ready_scheduler_macros.svh"

module periodic_task_ready_scheduler #(
	parameter int MAX_TASKS   = ptrs_pkg::PTRS_MAX_TASKS,
	parameter int COUNT_WIDTH = ptrs_pkg::PTRS_COUNT_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command
	input  logic                          start,
	output logic                          busy,
	input  logic [ptrs_pkg::OP_W-1:0]     op,
	input  logic [ptrs_pkg::TIDX_W-1:0]   task_index,
	input  logic [ptrs_pkg::PV_W-1:0]     period_value,
	// result
	output logic                          done,
	output logic [ptrs_pkg::MASK_W-1:0]   ready_mask,
	output logic [1:0]                    task_state,
	output logic                          index_valid,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ptrs_pkg::ACTIVE_W-1:0] cfg_data
);
	import ptrs_pkg::*;

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW    = ((IDX_W > ACTIVE_W) ? IDX_W : ACTIVE_W) + 1;

	// Sequencer and command registers
	seq_st_t             state_q, state_d;
	logic                accept, walking, last;
	logic [IDX_W-1:0]    step_q;
	op_t                 op_q;
	logic [TIDX_W-1:0]   idx_q;
	logic [PV_W-1:0]     pv_q;
	logic [ACTIVE_W-1:0] active_q;
	logic [MASK_W-1:0]   mask_q, mask_d;
	task_st_t            qst_q, qst_d;

	// Result registers
	logic                done_q;
	logic [MASK_W-1:0]   ready_mask_q;
	task_st_t            task_state_q;
	logic                index_valid_q;

	// Head signals
	logic [CW-1:0]          live_n;
	logic                   idx_ok;
	head_ctl_t              ctl;
	logic                   was_run;
	logic [COUNT_WIDTH-1:0] h_period, h_count;
	task_st_t               h_state;

	// Ring wiring
	logic [COUNT_WIDTH-1:0] c_period [MAX_TASKS];
	logic [COUNT_WIDTH-1:0] c_count  [MAX_TASKS];
	task_st_t               c_state  [MAX_TASKS];
	logic [COUNT_WIDTH-1:0] n_period [MAX_TASKS];
	logic [COUNT_WIDTH-1:0] n_count  [MAX_TASKS];
	task_st_t               n_state  [MAX_TASKS];

	assign accept  = start && (state_q == S_IDLE);
	assign walking = (state_q == S_WALK);
	assign last    = walking && (step_q == IDX_W'(MAX_TASKS - 1));

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		busy      = 1'b0;
		cfg_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				cfg_ready = 1'b1;
				if (start) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				busy = 1'b1;
				if (last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Active task count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	// Head control: entry number at the head equals step_q
	assign live_n  = (CW'(active_q) > CW'(MAX_TASKS)) ? CW'(MAX_TASKS) : CW'(active_q);
	assign idx_ok  = CW'(idx_q) < live_n;
	assign ctl.op   = op_q;
	assign ctl.live = CW'(step_q) < live_n;
	assign ctl.hit  = idx_ok && (CW'(idx_q) == CW'(step_q));

	ptrs_head #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_head (
		.ctl         (ctl),
		.period_value(pv_q),
		.i_period    (c_period[0]),
		.i_count     (c_count[0]),
		.i_state     (c_state[0]),
		.o_period    (h_period),
		.o_count     (h_count),
		.o_state     (h_state),
		.was_run     (was_run)
	);

	// Ring of cells: each takes its upper neighbor, the top cell takes the head result
	for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
		if (k == MAX_TASKS - 1) begin : g_top
			assign n_period[k] = h_period;
			assign n_count[k]  = h_count;
			assign n_state[k]  = h_state;
		end else begin : g_mid
			assign n_period[k] = c_period[k+1];
			assign n_count[k]  = c_count[k+1];
			assign n_state[k]  = c_state[k+1];
		end
		ptrs_cell #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (walking),
			.d_period(n_period[k]),
			.d_count (n_count[k]),
			.d_state (n_state[k]),
			.q_period(c_period[k]),
			.q_count (c_count[k]),
			.q_state (c_state[k])
		);
	end

	// Mask and query collection for the current step
	always_comb begin
		mask_d = mask_q;
		if (was_run && (CW'(step_q) < CW'(MASK_W))) begin
			mask_d[TIDX_W'(step_q)] = 1'b1;
		end
		qst_d = qst_q;
		if ((op_q == OP_QUERY) && ctl.hit) begin
			qst_d = c_state[0];
		end
	end

	// Command capture and walk progress
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(op);
			idx_q  <= task_index;
			pv_q   <= period_value;
			step_q <= '0;
			mask_q <= '0;
			qst_q  <= ST_STOP;
		end else if (walking) begin
			step_q <= step_q + IDX_W'(1);
			mask_q <= mask_d;
			qst_q  <= qst_d;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last;
		end
	end

	// Result payload, captured at the end of the walk
	always_ff @(posedge clk) begin
		if (last) begin
			ready_mask_q  <= mask_d;
			task_state_q  <= qst_d;
			index_valid_q <= idx_ok;
		end
	end

	assign done        = done_q;
	assign ready_mask  = ready_mask_q;
	assign task_state  = task_state_q;
	assign index_valid = index_valid_q;

	// Checks
	`PTRS_ASSERT_NOW(a_done_idle, done_q, !busy, "result strobe while walking")
	`PTRS_ASSERT_NEXT(a_start_walk, accept, busy, "accepted command did not start a walk")
	`PTRS_ASSERT_NEXT(a_last_done, last, done_q, "walk end gave no result strobe")
	`PTRS_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result strobe longer than one cycle")

endmodule

FILE: dv/ptrs_result_checker.sv
// Result checker for the periodic task ready scheduler: predicts every result and compares it.
module ptrs_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [ptrs_pkg::OP_W-1:0]     op,
	input  logic [ptrs_pkg::TIDX_W-1:0]   task_index,
	input  logic [ptrs_pkg::PV_W-1:0]     period_value,
	input  logic                          done,
	input  logic [ptrs_pkg::MASK_W-1:0]   ready_mask,
	input  logic [1:0]                    task_state,
	input  logic                          index_valid,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [ptrs_pkg::ACTIVE_W-1:0] cfg_data,
	output int                            mismatches,
	output int                            outstanding
);
	import ptrs_pkg::*;

	localparam int NTASK = PTRS_MAX_TASKS;
	localparam int NT_W  = $clog2(NTASK);

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [1:0]        state;
		logic              valid;
	} sched_out_t;

	// Shadow copy of the task table and the active count
	logic [PTRS_COUNT_WIDTH-1:0] period_tbl    [NTASK];
	logic [PTRS_COUNT_WIDTH-1:0] countdown_tbl [NTASK];
	task_st_t                    state_tbl     [NTASK];
	logic [ACTIVE_W-1:0]         active_cnt;

	sched_out_t sched_out_q [$];
	sched_out_t want;
	sched_out_t got;

	// Apply one command to the shadow table and work out its result
	task automatic advance_schedule(input logic [OP_W-1:0] cmd, input logic [TIDX_W-1:0] idx,
			input logic [PV_W-1:0] pv, output sched_out_t res);
		int live;
		int i;
		live = (active_cnt > NTASK) ? NTASK : int'(active_cnt);
		res = '0;
		res.valid = (int'(idx) < live);
		case (cmd)
			OP_TICK: begin
				for (i = 0; i < live; i++) begin
					if (state_tbl[NT_W'(i)] != ST_SUSP) begin
						if (countdown_tbl[NT_W'(i)] != 0)
							countdown_tbl[NT_W'(i)] = countdown_tbl[NT_W'(i)] - 1'b1;
						if (countdown_tbl[NT_W'(i)] == 0) begin
							state_tbl[NT_W'(i)] = ST_RUN;
							countdown_tbl[NT_W'(i)] = period_tbl[NT_W'(i)];
						end
					end
				end
			end
			OP_EXEC: begin
				for (i = 0; i < live; i++) begin
					if (state_tbl[NT_W'(i)] == ST_RUN) begin
						// entries past the mask width still return to stop
						if (i < MASK_W)
							res.mask[TIDX_W'(i)] = 1'b1;
						state_tbl[NT_W'(i)] = ST_STOP;
					end
				end
			end
			OP_SUSPEND: begin
				if (res.valid)
					state_tbl[idx] = ST_SUSP;
			end
			OP_RESUME: begin
				if (res.valid) begin
					countdown_tbl[idx] = period_tbl[idx];
					state_tbl[idx] = ST_RUN;
				end
			end
			OP_QUERY: begin
				if (res.valid)
					res.state = state_tbl[idx];
			end
			OP_LOAD: begin
				if (res.valid) begin
					period_tbl[idx] = PTRS_COUNT_WIDTH'(pv);
					countdown_tbl[idx] = PTRS_COUNT_WIDTH'(pv);
				end
			end
			default: ;
		endcase
	endtask

	// Watch result, config and command transfers at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NTASK; i++) begin
				period_tbl[NT_W'(i)] = '0;
				countdown_tbl[NT_W'(i)] = '0;
				state_tbl[NT_W'(i)] = ST_STOP;
			end
			active_cnt = ACTIVE_RESET;
			sched_out_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// result transfer
			if (done === 1'b1) begin
				got = {ready_mask, task_state, index_valid};
				if (sched_out_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing pending, got mask %h state %0d valid %0b",
						$time, got.mask, got.state, got.valid);
				end else begin
					want = sched_out_q.pop_front();
					if (got.mask !== want.mask) begin
						mismatches++;
						$display("%0t: ready_mask expected %h actual %h", $time, want.mask, got.mask);
					end
					if (got.state !== want.state) begin
						mismatches++;
						$display("%0t: task_state expected %0d actual %0d", $time,
							want.state, got.state);
					end
					if (got.valid !== want.valid) begin
						mismatches++;
						$display("%0t: index_valid expected %0b actual %0b", $time,
							want.valid, got.valid);
					end
				end
			end
			// config transfer
			if (cfg_valid && cfg_ready)
				active_cnt = cfg_data;
			// command transfer
			if (start && !busy) begin
				advance_schedule(op, task_index, period_value, want);
				sched_out_q.push_back(want);
			end
			outstanding = sched_out_q.size();
		end
	end

endmodule

FILE: dv/tb_periodic_task_ready_scheduler.sv
// Testbench top for the periodic task ready scheduler: stimulus, checker hookup and verdict.
module tb_periodic_task_ready_scheduler;
	import ptrs_pkg::*;

	// Op codes the block does not define
	localparam logic [OP_W-1:0] OP_UNDEF_A = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF_B = 3'd7;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic [OP_W-1:0]     op           = '0;
	logic [TIDX_W-1:0]   task_index   = '0;
	logic [PV_W-1:0]     period_value = '0;
	logic                cfg_valid    = 1'b0;
	logic [ACTIVE_W-1:0] cfg_data     = '0;
	logic                busy;
	logic                done;
	logic [MASK_W-1:0]   ready_mask;
	logic [1:0]          task_state;
	logic                index_valid;
	logic                cfg_ready;
	int                  mismatches;
	int                  outstanding;

	periodic_task_ready_scheduler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.task_index   (task_index),
		.period_value (period_value),
		.done         (done),
		.ready_mask   (ready_mask),
		.task_state   (task_state),
		.index_valid  (index_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	ptrs_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.task_index   (task_index),
		.period_value (period_value),
		.done         (done),
		.ready_mask   (ready_mask),
		.task_state   (task_state),
		.index_valid  (index_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// 10-unit clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("tb_periodic_task_ready_scheduler NOT OK");
		$finish;
	end

	// Mostly ticks, exec and loads so tasks actually come due
	function automatic logic [OP_W-1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 34)
			return OP_TICK;
		else if (r < 50)
			return OP_EXEC;
		else if (r < 58)
			return OP_SUSPEND;
		else if (r < 66)
			return OP_RESUME;
		else if (r < 80)
			return OP_QUERY;
		else if (r < 96)
			return OP_LOAD;
		else if (r < 98)
			return OP_UNDEF_A;
		else
			return OP_UNDEF_B;
	endfunction

	// Short periods dominate; full-range and all-ones values now and then
	function automatic logic [PV_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return PV_W'($urandom_range(0, 4));
		else if (r < 75)
			return PV_W'($urandom_range(0, 15));
		else if (r < 92)
			return PV_W'($urandom);
		else
			return '1;
	endfunction

	// One command transfer; entered and left at a falling edge
	task automatic issue(input logic [OP_W-1:0] c, input logic [TIDX_W-1:0] idx,
			input logic [PV_W-1:0] pv);
		start <= 1'b1;
		op <= c;
		task_index <= idx;
		period_value <= pv;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// Random sender gap after a transfer
	task automatic sender_gap(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 45)) @(negedge clk);
		end
	endtask

	// Stop sending and wait for every result to come back
	task automatic drain();
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Config transfer of the active count, only while idle
	task automatic set_active(input logic [ACTIVE_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [ACTIVE_W-1:0] act, input int items, input int pct);
		drain();
		set_active(act);
		repeat (items) begin
			issue(pick_op(), TIDX_W'($urandom_range(0, 15)), pick_period());
			sender_gap(pct);
		end
	endtask

	// Stimulus
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// oversized active count acts as full table
		set_active(5'd31);
		issue(OP_QUERY, 4'd0, 16'h0000);
		// zero periods: every entry comes due on the first tick
		issue(OP_TICK, 4'd0, 16'h0000);
		issue(OP_EXEC, 4'd0, 16'h0000);
		issue(OP_EXEC, 4'd0, 16'h0000);
		issue(OP_LOAD, 4'd15, 16'hFFFF);
		issue(OP_LOAD, 4'd0, 16'h0000);
		issue(OP_LOAD, 4'd3, 16'h0002);
		issue(OP_SUSPEND, 4'd5, 16'h0000);
		issue(OP_QUERY, 4'd5, 16'h0000);
		issue(OP_TICK, 4'd0, 16'h0000);
		issue(OP_QUERY, 4'd3, 16'h0000);
		issue(OP_TICK, 4'd0, 16'h0000);
		issue(OP_QUERY, 4'd3, 16'h0000);
		issue(OP_EXEC, 4'd0, 16'h0000);
		issue(OP_RESUME, 4'd5, 16'h0000);
		issue(OP_QUERY, 4'd5, 16'h0000);
		issue(OP_QUERY, 4'd15, 16'h0000);
		// undefined ops leave the table alone
		issue(OP_UNDEF_A, 4'd0, 16'h0000);
		issue(OP_UNDEF_B, 4'd15, 16'hFFFF);
		issue(OP_EXEC, 4'd0, 16'h0000);

		// no active entries: every index out of range
		drain();
		set_active(5'd0);
		issue(OP_QUERY, 4'd0, 16'h0000);
		issue(OP_LOAD, 4'd2, 16'h0007);
		issue(OP_TICK, 4'd0, 16'h0000);
		issue(OP_EXEC, 4'd0, 16'h0000);

		// random phases over several active counts and idle patterns
		run_phase(5'd16, 300, 0);
		run_phase(5'd31, 280, 62);
		run_phase(5'd1, 160, 17);
		run_phase(5'd9, 280, 62);
		run_phase(5'd0, 60, 0);
		run_phase(ACTIVE_W'($urandom_range(2, 15)), 300, 17);

		drain();
		repeat (PTRS_MAX_TASKS + 4) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_periodic_task_ready_scheduler OK");
		else
			$display("tb_periodic_task_ready_scheduler NOT OK");
		$finish;
	end

endmodule
